### rtl/core/rprop_parameter_update_unit_assert.svh
// Assertion macros for the RPROP parameter update unit.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef RPROP_PARAMETER_UPDATE_UNIT_ASSERT_SVH
`define RPROP_PARAMETER_UPDATE_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define RPROP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RPROP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RPROP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RPROP_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/core/rprop_pkg.sv
// Shared types and constants for the RPROP parameter update unit.
// No dependencies.
`timescale 1ns / 1ps
package rprop_pkg;
    localparam int PARAM_W  = 32;
    localparam int STEP_W   = 23;
    localparam int GROW_W   = 18;
    localparam int SHRINK_W = 17;
    localparam int CFG_IDX_W = 3;

    localparam logic [1:0] SIGN_NONE = 2'd0;
    localparam logic [1:0] SIGN_POS  = 2'd1;
    localparam logic [1:0] SIGN_NEG  = 2'd2;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_GRAD = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_STEP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_STEP      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GROW_FACTOR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHRINK_FACTOR = 3'd4;

    localparam logic [STEP_W-1:0]   RST_INITIAL_STEP  = 23'd6554;
    localparam logic [STEP_W-1:0]   RST_MAX_STEP      = 23'd3276800;
    localparam logic [STEP_W-1:0]   RST_MIN_STEP      = 23'd7;
    localparam logic [GROW_W-1:0]   RST_GROW_FACTOR   = 18'd78643;
    localparam logic [SHRINK_W-1:0] RST_SHRINK_FACTOR = 17'd32768;

    typedef struct packed {
        logic [STEP_W-1:0]   initial_step;
        logic [STEP_W-1:0]   max_step;
        logic [STEP_W-1:0]   min_step;
        logic [GROW_W-1:0]   grow_factor;
        logic [SHRINK_W-1:0] shrink_factor;
    } t_cfg;

    typedef struct packed {
        logic [PARAM_W-1:0] param;
        logic [STEP_W-1:0]  step;
        logic [1:0]         sign;
    } t_entry;
endpackage

### rtl/core/rprop_req_if.sv
// Request channel: valid/ready handshake with load or gradient payload.
// No dependencies.
`timescale 1ns / 1ps
interface rprop_req_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [2:0]         param_index;
    logic signed [31:0] param_value;
    logic signed [31:0] gradient;

    modport source (output valid, req_type, param_index, param_value, gradient,
                    input ready);
    modport sink   (input valid, req_type, param_index, param_value, gradient,
                    output ready);
endinterface

### rtl/core/rprop_rsp_if.sv
// Response channel: valid/ready handshake with updated parameter and step.
// No dependencies.
`timescale 1ns / 1ps
interface rprop_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] param_out;
    logic [22:0]        step_out;

    modport source (output valid, param_out, step_out, input ready);
    modport sink   (input valid, param_out, step_out, output ready);
endinterface

### rtl/core/rprop_calc.sv
// Per-item RPROP update of one entry: load, or sign compare, step scaling, saturating move.
// Depends on rprop_pkg.
`timescale 1ns / 1ps
module rprop_calc (
    input  rprop_pkg::t_cfg   i_cfg,
    input  logic              i_load,
    input  logic [31:0]       i_param_value,
    input  logic [31:0]       i_gradient,
    input  rprop_pkg::t_entry i_entry,
    output rprop_pkg::t_entry o_entry
);
    import rprop_pkg::*;

    logic [1:0]          sgn;
    logic                opposite;
    logic                agree;
    logic [GROW_W-1:0]   factor;
    logic [40:0]         prod;
    logic [STEP_W-1:0]   scaled;
    logic [STEP_W-1:0]   step_new;
    logic signed [33:0]  delta;
    logic signed [33:0]  sum;
    logic [PARAM_W-1:0]  moved;

    assign sgn = (i_gradient == '0) ? SIGN_NONE : (i_gradient[31] ? SIGN_NEG : SIGN_POS);
    assign opposite = (sgn != SIGN_NONE) && (i_entry.sign != SIGN_NONE) && (sgn != i_entry.sign);
    assign agree    = (sgn != SIGN_NONE) && (sgn == i_entry.sign);

    assign factor = opposite ? {1'b0, i_cfg.shrink_factor} : i_cfg.grow_factor;
    assign prod   = 41'(i_entry.step) * 41'(factor);
    // product >> 16, saturated to the step width
    assign scaled = (|prod[40:39]) ? {STEP_W{1'b1}} : prod[38:16];

    always_comb begin
        step_new = i_entry.step;
        if (opposite) begin
            step_new = (scaled < i_cfg.min_step) ? i_cfg.min_step : scaled;
        end else if (agree) begin
            step_new = (scaled > i_cfg.max_step) ? i_cfg.max_step : scaled;
        end
    end

    assign delta = (sgn == SIGN_POS) ? -$signed({11'b0, step_new}) : $signed({11'b0, step_new});
    assign sum   = $signed({{2{i_entry.param[31]}}, i_entry.param}) + delta;

    always_comb begin
        if (!sum[33] && (sum[32:31] != 2'b00)) begin
            moved = 32'h7FFF_FFFF;
        end else if (sum[33] && (sum[32:31] != 2'b11)) begin
            moved = 32'h8000_0000;
        end else begin
            moved = sum[31:0];
        end
    end

    always_comb begin
        if (i_load == REQ_LOAD) begin
            o_entry.param = i_param_value;
            o_entry.step  = i_cfg.initial_step;
            o_entry.sign  = SIGN_NONE;
        end else if (opposite) begin
            o_entry.param = i_entry.param;
            o_entry.step  = step_new;
            o_entry.sign  = SIGN_NONE;
        end else begin
            o_entry.param = (sgn == SIGN_NONE) ? i_entry.param : moved;
            o_entry.step  = step_new;
            o_entry.sign  = sgn;
        end
    end
endmodule

### rtl/core/rprop_parameter_update_unit.sv
// RPROP parameter update unit: state memory, read-modify-write pipeline, config registers.
// Depends on rprop_pkg, rprop_req_if, rprop_rsp_if, rprop_calc and the assertion header.
//
//  channel   dir  handshake       payload
//  i_req     in   valid/ready     req_type, param_index, param_value, gradient
//  o_rsp     out  valid/ready     param_out, step_out
//  i_cfg_*   in   write enable    i_cfg_index, i_cfg_data
//
// One item per cycle while results are taken; an input transfer is registered in the update
// stage and then in the result register, which drives the result valid.
// Transfer cycle reads the entry memory; the update stage then updates and writes it back
// when it advances, with a bypass register covering a back-to-back item on the same entry.
// Synchronous reset; step and sign of every entry read as reset values until written.
// A stalled result holds the update stage, which in turn holds the request side.
`timescale 1ns / 1ps
`include "rprop_parameter_update_unit_assert.svh"
module rprop_parameter_update_unit #(
    parameter int NUM_PARAMS = 3
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    rprop_req_if.sink                        i_req,
    rprop_rsp_if.source                      o_rsp,
    input  logic                             i_cfg_we,
    input  logic [rprop_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rprop_pkg::STEP_W-1:0]     i_cfg_data
);
    import rprop_pkg::*;

    localparam int IDX_W = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;

    t_cfg               r_cfg;
    t_entry             r_mem [NUM_PARAMS];
    logic [NUM_PARAMS-1:0] r_vld;

    logic               r_s1_vld;
    logic               r_s1_load;
    logic               r_s1_inr;
    logic [IDX_W-1:0]   r_s1_addr;
    logic [31:0]        r_s1_pv;
    logic [31:0]        r_s1_gv;
    t_entry             r_rd_data;
    logic               r_rd_vld;
    logic               r_byp;
    t_entry             r_byp_data;

    logic               r_out_vld;
    logic [31:0]        r_out_param;
    logic [STEP_W-1:0]  r_out_step;

    logic               in_fire;
    logic               s1_adv;
    logic [IDX_W-1:0]   addr_in;
    logic               inr_in;
    logic               wr_en;
    t_entry             entry_cur;
    t_entry             entry_new;

    assign s1_adv  = r_s1_vld && (!r_out_vld || o_rsp.ready);
    assign i_req.ready = !r_s1_vld || s1_adv;
    assign in_fire = i_req.valid && i_req.ready;
    assign addr_in = i_req.param_index[IDX_W-1:0];
    assign inr_in  = 4'(i_req.param_index) < 4'(NUM_PARAMS);
    assign wr_en   = s1_adv && r_s1_inr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.initial_step  <= RST_INITIAL_STEP;
            r_cfg.max_step      <= RST_MAX_STEP;
            r_cfg.min_step      <= RST_MIN_STEP;
            r_cfg.grow_factor   <= RST_GROW_FACTOR;
            r_cfg.shrink_factor <= RST_SHRINK_FACTOR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_INITIAL_STEP:  r_cfg.initial_step  <= i_cfg_data;
                CFG_MAX_STEP:      r_cfg.max_step      <= i_cfg_data;
                CFG_MIN_STEP:      r_cfg.min_step      <= i_cfg_data;
                CFG_GROW_FACTOR:   r_cfg.grow_factor   <= i_cfg_data[GROW_W-1:0];
                CFG_SHRINK_FACTOR: r_cfg.shrink_factor <= i_cfg_data[SHRINK_W-1:0];
                default: ;
            endcase
        end
    end

    // entry memory, read-before-write
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_rd_data <= r_mem[addr_in];
        end
        if (wr_en) begin
            r_mem[r_s1_addr] <= entry_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (wr_en) begin
            r_vld[r_s1_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_rd_vld <= 1'b0;
            r_byp    <= 1'b0;
        end else if (in_fire) begin
            r_s1_vld <= 1'b1;
            r_rd_vld <= r_vld[addr_in];
            r_byp    <= wr_en && (r_s1_addr == addr_in);
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_load  <= i_req.req_type;
            r_s1_inr   <= inr_in;
            r_s1_addr  <= addr_in;
            r_s1_pv    <= i_req.param_value;
            r_s1_gv    <= i_req.gradient;
            r_byp_data <= entry_new;
        end
    end

    always_comb begin
        if (r_byp) begin
            entry_cur = r_byp_data;
        end else if (r_rd_vld) begin
            entry_cur = r_rd_data;
        end else begin
            entry_cur.param = r_rd_data.param;
            entry_cur.step  = RST_INITIAL_STEP;
            entry_cur.sign  = SIGN_NONE;
        end
    end

    rprop_calc u_calc (
        .i_cfg         (r_cfg),
        .i_load        (r_s1_load),
        .i_param_value (r_s1_pv),
        .i_gradient    (r_s1_gv),
        .i_entry       (entry_cur),
        .o_entry       (entry_new)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_param <= r_s1_inr ? entry_new.param : '0;
            r_out_step  <= r_s1_inr ? entry_new.step  : '0;
        end
    end

    assign o_rsp.valid     = r_out_vld;
    assign o_rsp.param_out = r_out_param;
    assign o_rsp.step_out  = r_out_step;

    `RPROP_ASSERT_IMP(a_ready_only_when_busy, i_clk, i_rst_n, !i_req.ready, r_s1_vld)
    `RPROP_ASSERT_NXT(a_adv_gives_result, i_clk, i_rst_n, s1_adv, o_rsp.valid)
    `RPROP_ASSERT_NXT(a_out_of_range_zero, i_clk, i_rst_n, s1_adv && !r_s1_inr, (o_rsp.param_out == '0) && (o_rsp.step_out == '0))
endmodule
